/* rtl/lkc_pkg.sv */
`timescale 1ns / 1ps

package lkc_pkg;

  // Default geometry of the cache.
  localparam int ENTRIES_DEF = 16;
  localparam int KEY_BITS_DEF = 16;

  // Fixed field widths.
  localparam int CAP_BITS = 5;
  localparam int SLOT_BITS = 4;
  localparam int OUTCOME_BITS = 2;

  localparam logic [CAP_BITS-1:0] CAPACITY_RESET = CAP_BITS'(10);

  typedef enum logic [OUTCOME_BITS-1:0] {
    OUTCOME_HIT   = 2'd0,
    OUTCOME_FILL  = 2'd1,
    OUTCOME_EVICT = 2'd2
  } outcome_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic fire;      // request resolved this cycle
    logic hit;       // key found somewhere in the stack
    logic evict;     // miss at capacity
    logic fill_new;  // miss below capacity
  } cell_ctrl_t;

endpackage

/* rtl/lru_key_cache_policy_core.sv */
`timescale 1ns / 1ps
// Flow: an accepted request is held in the key register and resolves in the
//   compare/update stage into the output register once it is free or draining.
// Throughput: one request per cycle while the output side does not stall.
// Reset (rst, synchronous, active high): no slot in use, capacity back to 10,
//   both channels empty. Cell contents are not cleared; the fill count gates them.

module lru_key_cache_policy_core import lkc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration write: capacity
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CAP_BITS-1:0]     cfg_data,
  // request channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [KEY_BITS-1:0]     key,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OUTCOME_BITS-1:0] outcome,
  output logic [SLOT_BITS-1:0]    slot,
  output logic [KEY_BITS-1:0]     old_key
);

  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = ((CNT_W > CAP_BITS) ? CNT_W : CAP_BITS) + 1;

  // The recency stack is a row of cells: cell 0 holds the least recent entry,
  // cell fill_count-1 the most recent. A match ripples a found flag and the
  // hit slot upward; on a hit every cell from the match up takes its upper
  // neighbor and the top cell takes the hit entry. On eviction the whole
  // stack shifts down and the least recent slot is reused at the top.

  logic [CAP_BITS-1:0] capacity;
  logic [CNT_W-1:0]    fill_count;
  logic                busy;
  logic [KEY_BITS-1:0] key_q;
  logic                fire;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic [CMP_W-1:0] fill_ext;

  cell_ctrl_t ctrl;

  logic [ENTRIES:0]    found_chain;
  logic [SLOT_W-1:0]   slot_chain [ENTRIES+1];
  logic [SLOT_W-1:0]   entry_slot [ENTRIES];
  logic [KEY_BITS-1:0] entry_key  [ENTRIES];

  assign cfg_ready = 1'b1;

  // Effective capacity: zero acts as one, clamp at the number of cells.
  assign cap_ext  = CMP_W'(capacity);
  assign fill_ext = CMP_W'(fill_count);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Request resolves when the output register is free or draining.
  assign fire     = busy && (!out_valid || !out_stall);
  assign in_stall = busy && !fire;

  assign found_chain[0] = 1'b0;
  assign slot_chain[0]  = entry_slot[0];

  assign ctrl.fire     = fire;
  assign ctrl.hit      = found_chain[ENTRIES];
  assign ctrl.fill_new = !found_chain[ENTRIES] && (fill_ext < eff_cap);
  assign ctrl.evict    = !found_chain[ENTRIES] && (fill_ext >= eff_cap);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [SLOT_W-1:0]   nb_slot;
    logic [KEY_BITS-1:0] nb_key;

    if (i == ENTRIES - 1) begin : g_last
      // never shifts: no upper neighbor
      assign nb_slot = entry_slot[i];
      assign nb_key  = entry_key[i];
    end else begin : g_mid
      assign nb_slot = entry_slot[i+1];
      assign nb_key  = entry_key[i+1];
    end

    lkc_cell #(
      .KEY_BITS (KEY_BITS),
      .SLOT_W   (SLOT_W),
      .CNT_W    (CNT_W),
      .POS      (i)
    ) u_cell (
      .clk            (clk),
      .ctrl           (ctrl),
      .fill_count     (fill_count),
      .req_key        (key_q),
      .found_in       (found_chain[i]),
      .chain_slot_in  (slot_chain[i]),
      .found_out      (found_chain[i+1]),
      .chain_slot_out (slot_chain[i+1]),
      .nb_slot        (nb_slot),
      .nb_key         (nb_key),
      .entry_slot     (entry_slot[i]),
      .entry_key      (entry_key[i])
    );
  end

  // Control and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAPACITY_RESET;
      fill_count <= '0;
      busy       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        busy <= 1'b1;
      end else if (fire) begin
        busy <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (fire && ctrl.fill_new) begin
        fill_count <= fill_count + CNT_W'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      key_q <= key;
    end
    if (fire) begin
      if (ctrl.hit) begin
        outcome <= OUTCOME_HIT;
        slot    <= SLOT_BITS'(slot_chain[ENTRIES]);
        old_key <= '0;
      end else if (ctrl.fill_new) begin
        outcome <= OUTCOME_FILL;
        slot    <= SLOT_BITS'(fill_count);
        old_key <= '0;
      end else begin
        outcome <= OUTCOME_EVICT;
        slot    <= SLOT_BITS'(slot_chain[ENTRIES]);
        old_key <= entry_key[0];
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(ENTRIES))
    else $error("fill count above cell count");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    fire && ctrl.fill_new |=> fill_count == $past(fill_count) + CNT_W'(1))
    else $error("fill count did not advance on a fill");

  a_evict_nonempty: assert property (@(posedge clk) disable iff (rst)
    fire && ctrl.evict |-> fill_count != '0)
    else $error("eviction with an empty stack");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid && !busy || out_valid && $past(in_valid && !in_stall))
    else $error("resolved request lost");

endmodule

/* rtl/lkc_cell.sv */
`timescale 1ns / 1ps

module lkc_cell import lkc_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int SLOT_W = 4,
  parameter int CNT_W = 5,
  parameter int POS = 0
) (
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic [CNT_W-1:0]    fill_count,
  input  logic [KEY_BITS-1:0] req_key,
  // compare chain from the less recent neighbor
  input  logic                found_in,
  input  logic [SLOT_W-1:0]   chain_slot_in,
  output logic                found_out,
  output logic [SLOT_W-1:0]   chain_slot_out,
  // entry of the more recent neighbor
  input  logic [SLOT_W-1:0]   nb_slot,
  input  logic [KEY_BITS-1:0] nb_key,
  // own entry
  output logic [SLOT_W-1:0]   entry_slot,
  output logic [KEY_BITS-1:0] entry_key
);

  logic in_use;
  logic is_top;
  logic at_fill;
  logic match;

  assign in_use  = CNT_W'(POS) < fill_count;
  assign is_top  = CNT_W'(POS + 1) == fill_count;
  assign at_fill = CNT_W'(POS) == fill_count;
  assign match   = in_use && (entry_key == req_key);

  // First match wins; with no match the chain carries the least recent slot.
  assign found_out      = found_in | match;
  assign chain_slot_out = (!found_in && match) ? entry_slot : chain_slot_in;

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      if ((ctrl.hit || ctrl.evict) && is_top) begin
        entry_slot <= chain_slot_out;
        entry_key  <= req_key;
      end else if ((ctrl.evict || (ctrl.hit && found_out)) && in_use && !is_top) begin
        entry_slot <= nb_slot;
        entry_key  <= nb_key;
      end else if (ctrl.fill_new && at_fill) begin
        entry_slot <= SLOT_W'(POS);
        entry_key  <= req_key;
      end
    end
  end

endmodule
